>>> rtl/complex_arith_alu_macros.svh
// assertion macros shared by the checker
`ifndef COMPLEX_ARITH_ALU_MACROS_SVH
`define COMPLEX_ARITH_ALU_MACROS_SVH

// property checked outside reset
`define CAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cal assertion failed");

// property checked at every edge, reset included
`define CAL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("cal assertion failed");

`endif

>>> rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Action codes, status codes and register addresses of the complex ALU.
// ----------------------------------------------------------------------------
package cal_pkg;

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4,
        ACT_NEG  = 3'd5,
        ACT_EQ   = 3'd6
    } t_action;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_DIV0 = 2'd1;
    localparam t_status ST_SAT  = 2'd2;

    localparam logic REG_EQ_TOL = 1'b0;

endpackage

>>> rtl/cal_front.sv
// ----------------------------------------------------------------------------
// cal_front
// Operand capture, products, simple actions, multiply result and divider set-up.
// ----------------------------------------------------------------------------
module cal_front #(
    parameter int DW = 32,
    parameter int F  = 16,
    localparam int MW = 2 * DW,
    localparam int XW = 3 * DW + F + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [2:0]           i_act,
    input  logic signed [DW-1:0] i_a_re,
    input  logic signed [DW-1:0] i_a_im,
    input  logic signed [DW-1:0] i_b_re,
    input  logic signed [DW-1:0] i_b_im,
    input  logic [15:0]          i_tol,
    output logic                 o_vld,
    output logic                 o_is_div,
    output logic [DW-1:0]        o_alt_re,
    output logic [DW-1:0]        o_alt_im,
    output logic                 o_alt_ovf,
    output logic                 o_eq,
    output logic                 o_den_zero,
    output logic                 o_neg_re,
    output logic                 o_neg_im,
    output logic                 o_pre_re,
    output logic                 o_pre_im,
    output logic [XW-1:0]        o_rem_re,
    output logic [XW-1:0]        o_rem_im,
    output logic [MW-1:0]        o_den
);

    localparam int SW = 2 * DW + 1;
    localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    function automatic logic [DW:0] sat_fn(input logic signed [SW-1:0] v);
        if (v > SMAX) begin
            return {1'b1, SMAX[DW-1:0]};
        end else if (v < SMIN) begin
            return {1'b1, SMIN[DW-1:0]};
        end
        return {1'b0, v[DW-1:0]};
    endfunction

    // stage 1: operand capture
    logic                 r1_vld;
    logic [2:0]           r1_act;
    logic signed [DW-1:0] r1_ar, r1_ai, r1_br, r1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_act <= i_act;
        r1_ar  <= i_a_re;
        r1_ai  <= i_a_im;
        r1_br  <= i_b_re;
        r1_bi  <= i_b_im;
    end

    // stage 2: products and simple actions
    logic signed [DW:0]   n_e_re, n_e_im, n_d_re, n_d_im;
    logic [DW:0]          n_ad_re, n_ad_im, n_tol;
    logic [DW:0]          n_s_re, n_s_im;
    logic                 n_eq;

    always_comb begin
        n_e_re = '0;
        n_e_im = '0;
        case (cal_pkg::t_action'(r1_act))
            cal_pkg::ACT_ADD: begin
                n_e_re = (DW+1)'(r1_ar) + (DW+1)'(r1_br);
                n_e_im = (DW+1)'(r1_ai) + (DW+1)'(r1_bi);
            end
            cal_pkg::ACT_SUB: begin
                n_e_re = (DW+1)'(r1_ar) - (DW+1)'(r1_br);
                n_e_im = (DW+1)'(r1_ai) - (DW+1)'(r1_bi);
            end
            cal_pkg::ACT_CONJ: begin
                n_e_re = (DW+1)'(r1_ar);
                n_e_im = -(DW+1)'(r1_ai);
            end
            cal_pkg::ACT_NEG: begin
                n_e_re = -(DW+1)'(r1_ar);
                n_e_im = -(DW+1)'(r1_ai);
            end
            default: begin
                n_e_re = '0;
                n_e_im = '0;
            end
        endcase
        n_s_re = sat_fn(SW'(n_e_re));
        n_s_im = sat_fn(SW'(n_e_im));

        n_d_re  = (DW+1)'(r1_ar) - (DW+1)'(r1_br);
        n_d_im  = (DW+1)'(r1_ai) - (DW+1)'(r1_bi);
        n_ad_re = n_d_re[DW] ? (DW+1)'(-n_d_re) : n_d_re;
        n_ad_im = n_d_im[DW] ? (DW+1)'(-n_d_im) : n_d_im;
        n_tol   = (DW+1)'(i_tol);
        n_eq    = (r1_act == cal_pkg::ACT_EQ) &&
                  ((n_ad_re == '0) || (n_ad_re < n_tol)) &&
                  ((n_ad_im == '0) || (n_ad_im < n_tol));
    end

    logic                 r2_vld;
    logic [2:0]           r2_act;
    logic signed [MW-1:0] r2_prr, r2_pii, r2_pri, r2_pir, r2_pbr, r2_pbi;
    logic [DW-1:0]        r2_s_re, r2_s_im;
    logic                 r2_s_ovf, r2_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_act   <= r1_act;
        r2_prr   <= MW'(r1_ar) * MW'(r1_br);
        r2_pii   <= MW'(r1_ai) * MW'(r1_bi);
        r2_pri   <= MW'(r1_ar) * MW'(r1_bi);
        r2_pir   <= MW'(r1_ai) * MW'(r1_br);
        r2_pbr   <= MW'(r1_br) * MW'(r1_br);
        r2_pbi   <= MW'(r1_bi) * MW'(r1_bi);
        r2_s_re  <= n_s_re[DW-1:0];
        r2_s_im  <= n_s_im[DW-1:0];
        r2_s_ovf <= n_s_re[DW] | n_s_im[DW];
        r2_eq    <= n_eq;
    end

    // stage 3: multiply result and divider set-up
    logic signed [SW-1:0] n_ms_re, n_ms_im, n_mh_re, n_mh_im, n_nr, n_ni;
    logic [DW:0]          n_m_re, n_m_im;
    logic [MW-1:0]        n_mag_re, n_mag_im, n_den;
    logic [XW-1:0]        n_x_re, n_x_im, n_dlim;
    logic                 n_is_mul;

    always_comb begin
        n_ms_re  = SW'(r2_prr) - SW'(r2_pii);
        n_ms_im  = SW'(r2_pri) + SW'(r2_pir);
        n_mh_re  = n_ms_re >>> F;
        n_mh_im  = n_ms_im >>> F;
        n_m_re   = sat_fn(n_mh_re);
        n_m_im   = sat_fn(n_mh_im);
        n_is_mul = (r2_act == cal_pkg::ACT_MUL);

        n_nr     = SW'(r2_prr) + SW'(r2_pii);
        n_ni     = SW'(r2_pir) - SW'(r2_pri);
        n_mag_re = n_nr[SW-1] ? MW'(-n_nr) : MW'(n_nr);
        n_mag_im = n_ni[SW-1] ? MW'(-n_ni) : MW'(n_ni);
        n_x_re   = XW'(n_mag_re) << F;
        n_x_im   = XW'(n_mag_im) << F;
        n_den    = MW'(r2_pbr) + MW'(r2_pbi);
        n_dlim   = XW'(n_den) << (DW + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r2_vld;
        end
        o_is_div   <= (r2_act == cal_pkg::ACT_DIV);
        o_alt_re   <= n_is_mul ? n_m_re[DW-1:0] : r2_s_re;
        o_alt_im   <= n_is_mul ? n_m_im[DW-1:0] : r2_s_im;
        o_alt_ovf  <= n_is_mul ? (n_m_re[DW] | n_m_im[DW]) : r2_s_ovf;
        o_eq       <= r2_eq;
        o_den_zero <= (n_den == '0);
        o_neg_re   <= n_nr[SW-1];
        o_neg_im   <= n_ni[SW-1];
        o_pre_re   <= (n_x_re >= n_dlim);
        o_pre_im   <= (n_x_im >= n_dlim);
        o_rem_re   <= n_x_re;
        o_rem_im   <= n_x_im;
        o_den      <= n_den;
    end

endmodule

>>> rtl/cal_div_step.sv
// ----------------------------------------------------------------------------
// cal_div_step
// One restoring division step for both quotient lanes, one quotient bit.
// ----------------------------------------------------------------------------
module cal_div_step #(
    parameter int DW = 32,
    parameter int F  = 16,
    parameter int K  = 0,
    localparam int MW = 2 * DW,
    localparam int XW = 3 * DW + F + 2,
    localparam int QW = DW + 1
) (
    input  logic          i_clk,
    input  logic [XW-1:0] i_rem_re,
    input  logic [XW-1:0] i_rem_im,
    input  logic [MW-1:0] i_den,
    input  logic [QW-1:0] i_q_re,
    input  logic [QW-1:0] i_q_im,
    output logic [XW-1:0] o_rem_re,
    output logic [XW-1:0] o_rem_im,
    output logic [MW-1:0] o_den,
    output logic [QW-1:0] o_q_re,
    output logic [QW-1:0] o_q_im
);

    logic [XW-1:0] n_dsh;
    logic          n_ge_re, n_ge_im;
    logic [QW-1:0] n_q_re, n_q_im;

    always_comb begin
        n_dsh     = XW'(i_den) << K;
        n_ge_re   = (i_rem_re >= n_dsh);
        n_ge_im   = (i_rem_im >= n_dsh);
        n_q_re    = i_q_re;
        n_q_im    = i_q_im;
        n_q_re[K] = n_ge_re;
        n_q_im[K] = n_ge_im;
    end

    always_ff @(posedge i_clk) begin
        o_rem_re <= n_ge_re ? (i_rem_re - n_dsh) : i_rem_re;
        o_rem_im <= n_ge_im ? (i_rem_im - n_dsh) : i_rem_im;
        o_den    <= i_den;
        o_q_re   <= n_q_re;
        o_q_im   <= n_q_im;
    end

endmodule

>>> rtl/complex_arith_alu.sv
// ----------------------------------------------------------------------------
// complex_arith_alu
// Pipelined complex ALU on signed fixed-point operands with saturation.
// ----------------------------------------------------------------------------
// usage
//   an item (action, a, b) is taken at each clock edge with i_start high;
//   o_busy stays low, so an item may enter in every cycle
//   each item gives one result, shown for one cycle with o_valid high
//   every action passes through the same stages: three front stages,
//   one divider stage per quotient bit (DATA_WIDTH + 1 of them) and
//   the output register
//   throughput is one item per cycle, set by the bit-per-stage divider
//   the receiver cannot stall; results go out in the order items came in
//   reset empties the pipeline and clears the tolerance register to zero
//   the tolerance register lies at address 0 of the apb port; the block
//   leaves it to the user to write it only while no item is in flight
// ----------------------------------------------------------------------------
module complex_arith_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_action,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_r_re,
    output logic signed [DATA_WIDTH-1:0] o_r_im,
    output logic                         o_is_equal,
    output logic [1:0]                   o_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DW = DATA_WIDTH;
    localparam int MW = 2 * DW;
    localparam int XW = 3 * DW + FRAC_BITS + 2;
    localparam int QW = DW + 1;
    localparam int ND = DW + 1;

    typedef struct packed {
        logic          is_div;
        logic [DW-1:0] alt_re;
        logic [DW-1:0] alt_im;
        logic          alt_ovf;
        logic          eq;
        logic          den_zero;
        logic          neg_re;
        logic          neg_im;
        logic          pre_re;
        logic          pre_im;
    } t_side;

    // configuration
    logic [15:0] r_tol;

    assign pready = 1'b1;
    assign o_busy = 1'b0;
    assign prdata = (paddr[2] == cal_pkg::REG_EQ_TOL) ? {16'b0, r_tol} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == cal_pkg::REG_EQ_TOL)) begin
            r_tol <= pwdata[15:0];
        end
    end

    // front stages
    logic          w_vld;
    t_side         w_side;
    logic [XW-1:0] w_rem_re [0:ND];
    logic [XW-1:0] w_rem_im [0:ND];
    logic [MW-1:0] w_den    [0:ND];
    logic [QW-1:0] w_q_re   [0:ND];
    logic [QW-1:0] w_q_im   [0:ND];

    cal_front #(
        .DW (DW),
        .F  (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_start && !o_busy),
        .i_act      (i_action),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .i_tol      (r_tol),
        .o_vld      (w_vld),
        .o_is_div   (w_side.is_div),
        .o_alt_re   (w_side.alt_re),
        .o_alt_im   (w_side.alt_im),
        .o_alt_ovf  (w_side.alt_ovf),
        .o_eq       (w_side.eq),
        .o_den_zero (w_side.den_zero),
        .o_neg_re   (w_side.neg_re),
        .o_neg_im   (w_side.neg_im),
        .o_pre_re   (w_side.pre_re),
        .o_pre_im   (w_side.pre_im),
        .o_rem_re   (w_rem_re[0]),
        .o_rem_im   (w_rem_im[0]),
        .o_den      (w_den[0])
    );

    assign w_q_re[0] = '0;
    assign w_q_im[0] = '0;

    // divider, one quotient bit per stage, top bit first
    for (genvar j = 0; j < ND; j++) begin : g_div
        cal_div_step #(
            .DW (DW),
            .F  (FRAC_BITS),
            .K  (DW - j)
        ) u_step (
            .i_clk    (i_clk),
            .i_rem_re (w_rem_re[j]),
            .i_rem_im (w_rem_im[j]),
            .i_den    (w_den[j]),
            .i_q_re   (w_q_re[j]),
            .i_q_im   (w_q_im[j]),
            .o_rem_re (w_rem_re[j+1]),
            .o_rem_im (w_rem_im[j+1]),
            .o_den    (w_den[j+1]),
            .o_q_re   (w_q_re[j+1]),
            .o_q_im   (w_q_im[j+1])
        );
    end

    // side data and valid bits alongside the divider
    logic  r_svld [0:ND-1];
    t_side r_side [0:ND-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ND; i++) begin
                r_svld[i] <= 1'b0;
            end
        end else begin
            r_svld[0] <= w_vld;
            for (int i = 1; i < ND; i++) begin
                r_svld[i] <= r_svld[i-1];
            end
        end
        r_side[0] <= w_side;
        for (int i = 1; i < ND; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // quotient saturation and result select
    localparam logic [QW-1:0] QPOS = {2'b00, {(DW-1){1'b1}}};
    localparam logic [QW-1:0] QNEG = {2'b01, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    t_side         w_fs;
    logic [QW-1:0] w_qr, w_qi;
    logic          n_ovr, n_ovi;
    logic [DW-1:0] n_dr, n_di, n_re, n_im;
    logic          n_eq;
    logic [1:0]    n_st;

    assign w_fs = r_side[ND-1];
    assign w_qr = w_q_re[ND];
    assign w_qi = w_q_im[ND];

    always_comb begin
        n_ovr = w_fs.pre_re | (w_fs.neg_re ? (w_qr > QNEG) : (w_qr > QPOS));
        n_ovi = w_fs.pre_im | (w_fs.neg_im ? (w_qi > QNEG) : (w_qi > QPOS));
        if (n_ovr) begin
            n_dr = w_fs.neg_re ? DMIN : DMAX;
        end else begin
            n_dr = w_fs.neg_re ? DW'(-w_qr) : w_qr[DW-1:0];
        end
        if (n_ovi) begin
            n_di = w_fs.neg_im ? DMIN : DMAX;
        end else begin
            n_di = w_fs.neg_im ? DW'(-w_qi) : w_qi[DW-1:0];
        end

        if (w_fs.is_div) begin
            n_eq = 1'b0;
            if (w_fs.den_zero) begin
                n_re = '0;
                n_im = '0;
                n_st = cal_pkg::ST_DIV0;
            end else begin
                n_re = n_dr;
                n_im = n_di;
                n_st = (n_ovr | n_ovi) ? cal_pkg::ST_SAT : cal_pkg::ST_OK;
            end
        end else begin
            n_re = w_fs.alt_re;
            n_im = w_fs.alt_im;
            n_eq = w_fs.eq;
            n_st = w_fs.alt_ovf ? cal_pkg::ST_SAT : cal_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_svld[ND-1];
        end
        o_r_re     <= n_re;
        o_r_im     <= n_im;
        o_is_equal <= n_eq;
        o_status   <= n_st;
    end

endmodule

>>> rtl/cal_checker.sv
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks of the complex ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "complex_arith_alu_macros.svh"

module cal_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_start,
    input logic                  o_busy,
    input logic                  o_valid,
    input logic [DATA_WIDTH-1:0] o_r_re,
    input logic [DATA_WIDTH-1:0] o_r_im,
    input logic                  o_is_equal,
    input logic [1:0]            o_status
);

    localparam int LAT = DATA_WIDTH + 5;

    // empty pipeline right after reset
    `CAL_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // every item taken in comes out with o_valid high at the end of the pipeline
    `CAL_ASSERT(a_latency, i_clk, i_rst_n, (i_start && !o_busy) |-> ##LAT o_valid)

    // divide by zero gives a zero result
    `CAL_ASSERT(a_div0_zero, i_clk, i_rst_n, (o_valid && (o_status == cal_pkg::ST_DIV0)) |-> ((o_r_re == '0) && (o_r_im == '0) && !o_is_equal))

    // a compare that finds the operands equal gives a zero result with ok status
    `CAL_ASSERT(a_eq_clean, i_clk, i_rst_n, (o_valid && o_is_equal) |-> ((o_r_re == '0) && (o_r_im == '0) && (o_status == cal_pkg::ST_OK)))

endmodule

bind complex_arith_alu cal_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cal_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_r_re     (o_r_re),
    .o_r_im     (o_r_im),
    .o_is_equal (o_is_equal),
    .o_status   (o_status)
);
